[src/rail_fence_transposer_assert.svh]
// ----------------------------------------------------------------------------
// Rail fence transposer assertion macros
// Shared property wrappers for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef RAIL_FENCE_TRANSPOSER_ASSERT_SVH
`define RAIL_FENCE_TRANSPOSER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RFT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("rail fence transposer assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RFT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("rail fence transposer assertion failed");

`endif

[src/rft_pkg.sv]
// ----------------------------------------------------------------------------
// Rail fence transposer package
// Payload types, controller interface types, sizes and register codes.
// ----------------------------------------------------------------------------
package rft_pkg;

  localparam int MaxLen = 64;
  localparam int AddrW  = $clog2(MaxLen);
  localparam int LenW   = $clog2(MaxLen + 1);
  localparam int RailW  = 7;
  // largest position visited: last stored position plus one full period
  localparam int PosW   = $clog2(MaxLen + 2 * (2 ** RailW) - 1);
  localparam int StepW  = RailW + 1;

  localparam int PaddrW = 3;
  localparam int PdataW = 32;

  // register index as seen at paddr[2]
  localparam logic RegIdxRail = 1'b0;
  localparam logic RegIdxMode = 1'b1;

  localparam logic [RailW-1:0] RailReset = RailW'(3);

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } rft_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       truncated;
  } rft_out_t;

  typedef enum logic [1:0] {
    StLoad,
    StPerm,
    StOutRd,
    StOutSend
  } rft_state_e;

  typedef struct packed {
    logic load;
    logic start;
    logic perm;
    logic out_rd;
    logic out_take;
  } rft_cmd_t;

  typedef struct packed {
    logic perm_done;
    logic out_last;
  } rft_status_t;

endpackage

[src/rft_cfg_regs.sv]
// ----------------------------------------------------------------------------
// Rail fence transposer configuration registers
// APB-style register file holding the rail count and the mode bit.
// ----------------------------------------------------------------------------
module rft_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rft_pkg::PaddrW-1:0] paddr,
  input  logic [rft_pkg::PdataW-1:0] pwdata,
  output logic [rft_pkg::PdataW-1:0] prdata,
  output logic                       pready,
  output logic [rft_pkg::RailW-1:0]  rail_count_o,
  output logic                       decrypt_mode_o
);
  import rft_pkg::*;

  logic [RailW-1:0] rail_q, rail_d;
  logic             mode_q, mode_d;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    rail_d = rail_q;
    mode_d = mode_q;
    if (wr_en) begin
      case (paddr[2])
        RegIdxRail: rail_d = pwdata[RailW-1:0];
        RegIdxMode: mode_d = pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rail_q <= RailReset;
      mode_q <= 1'b0;
    end else begin
      rail_q <= rail_d;
      mode_q <= mode_d;
    end
  end

  always_comb begin
    case (paddr[2])
      RegIdxRail: prdata = PdataW'(rail_q);
      RegIdxMode: prdata = PdataW'(mode_q);
      default:    prdata = '0;
    endcase
  end

  assign rail_count_o   = rail_q;
  assign decrypt_mode_o = mode_q;

endmodule

[src/rft_ctrl.sv]
// ----------------------------------------------------------------------------
// Rail fence transposer controller
// Sequences load, permutation pass and output stream of one message.
// ----------------------------------------------------------------------------
module rft_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_last_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  rft_pkg::rft_status_t status_i,
  output rft_pkg::rft_cmd_t    cmd_o
);
  import rft_pkg::*;

  rft_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StLoad: begin
        if (in_valid_i && in_last_i) state_d = StPerm;
      end
      StPerm: begin
        if (status_i.perm_done) state_d = StOutRd;
      end
      StOutRd: begin
        state_d = StOutSend;
      end
      StOutSend: begin
        if (out_ready_i) state_d = status_i.out_last ? StLoad : StOutRd;
      end
      default: state_d = StLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      StLoad: begin
        in_ready_o  = 1'b1;
        cmd_o.load  = in_valid_i;
        cmd_o.start = in_valid_i && in_last_i;
      end
      StPerm: begin
        cmd_o.perm = 1'b1;
      end
      StOutRd: begin
        cmd_o.out_rd = 1'b1;
      end
      StOutSend: begin
        out_valid_o    = 1'b1;
        cmd_o.out_take = out_ready_i;
      end
      default: ;
    endcase
  end

endmodule

[src/rft_datapath.sv]
// ----------------------------------------------------------------------------
// Rail fence transposer datapath
// Message buffer, zigzag position walker and output buffer.
// ----------------------------------------------------------------------------
module rft_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rft_pkg::rft_cmd_t         cmd_i,
  output rft_pkg::rft_status_t      status_o,
  input  rft_pkg::rft_in_t          in_data_i,
  output rft_pkg::rft_out_t         out_data_o,
  input  logic [rft_pkg::RailW-1:0] rail_count_i,
  input  logic                      decrypt_mode_i
);
  import rft_pkg::*;

  logic [7:0] store_mem [MaxLen];
  logic [7:0] obuf_mem  [MaxLen];

  logic [LenW-1:0]  len_q, len_d;
  logic             ovf_q, ovf_d;
  logic [LenW-1:0]  k_q, k_d;
  logic [AddrW-1:0] j_q, j_d;
  logic [RailW-1:0] rail_q, rail_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic             phase_q, phase_d;
  logic             wen_q, wen_d;
  logic [AddrW-1:0] wa_q, wa_d;
  logic [7:0]       store_rd_q;
  logic [7:0]       obuf_rd_q;

  logic             has_room;
  logic             pass_thru;
  logic             perm_done;
  logic             in_range;
  logic             emit;
  logic [StepW-1:0] step_a, step_b, step_sel, step_alt, step;
  logic [AddrW-1:0] raddr;

  assign has_room  = len_q < LenW'(MaxLen);
  assign pass_thru = rail_count_i < RailW'(2);
  assign perm_done = k_q == len_q;
  assign in_range  = pos_q < PosW'(len_q);
  assign emit      = cmd_i.perm && !perm_done && in_range;

  // middle rails alternate the down and up gaps; edge rails have one nonzero gap
  assign step_a   = {rail_count_i - RailW'(1) - rail_q, 1'b0};
  assign step_b   = {rail_q, 1'b0};
  assign step_sel = phase_q ? step_b : step_a;
  assign step_alt = phase_q ? step_a : step_b;
  assign step     = pass_thru ? StepW'(1) :
                    ((step_sel == '0) ? step_alt : step_sel);

  assign raddr = decrypt_mode_i ? k_q[AddrW-1:0] : pos_q[AddrW-1:0];

  always_comb begin
    len_d   = len_q;
    ovf_d   = ovf_q;
    k_d     = k_q;
    j_d     = j_q;
    rail_d  = rail_q;
    pos_d   = pos_q;
    phase_d = phase_q;
    wen_d   = 1'b0;
    wa_d    = decrypt_mode_i ? pos_q[AddrW-1:0] : k_q[AddrW-1:0];

    if (cmd_i.load) begin
      if (has_room) len_d = len_q + LenW'(1);
      else          ovf_d = 1'b1;
    end
    if (cmd_i.start) begin
      k_d     = '0;
      j_d     = '0;
      rail_d  = '0;
      pos_d   = '0;
      phase_d = 1'b0;
    end
    if (cmd_i.perm && !perm_done) begin
      if (in_range) begin
        wen_d   = 1'b1;
        k_d     = k_q + LenW'(1);
        pos_d   = pos_q + PosW'(step);
        phase_d = !phase_q;
      end else begin
        // rail exhausted: advance to the next one
        rail_d  = rail_q + RailW'(1);
        pos_d   = PosW'(rail_q) + PosW'(1);
        phase_d = 1'b0;
      end
    end
    if (cmd_i.out_take) begin
      if (status_o.out_last) begin
        len_d = '0;
        ovf_d = 1'b0;
      end else begin
        j_d = j_q + AddrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      ovf_q   <= 1'b0;
      k_q     <= '0;
      j_q     <= '0;
      rail_q  <= '0;
      pos_q   <= '0;
      phase_q <= 1'b0;
      wen_q   <= 1'b0;
    end else begin
      len_q   <= len_d;
      ovf_q   <= ovf_d;
      k_q     <= k_d;
      j_q     <= j_d;
      rail_q  <= rail_d;
      pos_q   <= pos_d;
      phase_q <= phase_d;
      wen_q   <= wen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wa_q <= wa_d;
  end

  // message buffer: written while loading, read during the permutation pass
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && has_room) store_mem[len_q[AddrW-1:0]] <= in_data_i.in_byte;
    if (emit) store_rd_q <= store_mem[raddr];
  end

  // output buffer: scattered or gathered into output order, then streamed
  always_ff @(posedge clk_i) begin
    if (wen_q) obuf_mem[wa_q] <= store_rd_q;
    if (cmd_i.out_rd) obuf_rd_q <= obuf_mem[j_q];
  end

  assign status_o.perm_done = perm_done;
  assign status_o.out_last  = LenW'(j_q) == (len_q - LenW'(1));

  assign out_data_o.out_byte  = obuf_rd_q;
  assign out_data_o.out_last  = status_o.out_last;
  assign out_data_o.truncated = ovf_q;

endmodule

[src/rail_fence_transposer.sv]
// Loading accepts a byte whenever one is offered. After the last byte the permutation
//   pass walks the message rail by rail, moving one byte at each in-range position and
//   stepping to the next rail when one is exhausted; each output byte is then read from
//   the output buffer port and held until taken. Input reopens after the last output byte.
// Reset: asynchronous, active low; clears length, overflow flag and controller,
//   sets rail count 3 and encrypt mode. Buffer contents stay undefined.
// ----------------------------------------------------------------------------
// Rail fence transposer
// Buffers a message and emits its zigzag transposition or its inverse.
// ----------------------------------------------------------------------------
module rail_fence_transposer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  rft_pkg::rft_in_t           in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output rft_pkg::rft_out_t          out_data_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rft_pkg::PaddrW-1:0] paddr,
  input  logic [rft_pkg::PdataW-1:0] pwdata,
  output logic [rft_pkg::PdataW-1:0] prdata,
  output logic                       pready
);
  import rft_pkg::*;

  rft_cmd_t         cmd;
  rft_status_t      status;
  logic [RailW-1:0] rail_count;
  logic             decrypt_mode;

  rft_cfg_regs u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .rail_count_o   (rail_count),
    .decrypt_mode_o (decrypt_mode)
  );

  rft_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_last_i   (in_data_i.in_last),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  rft_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .in_data_i      (in_data_i),
    .out_data_o     (out_data_o),
    .rail_count_i   (rail_count),
    .decrypt_mode_i (decrypt_mode)
  );

endmodule

[src/rft_checker.sv]
// ----------------------------------------------------------------------------
// Rail fence transposer checker
// Port-level properties of the message handshake, bound to the top level.
// ----------------------------------------------------------------------------
`include "rail_fence_transposer_assert.svh"

module rft_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input rft_pkg::rft_in_t           in_data_i,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input rft_pkg::rft_out_t          out_data_o
);
  import rft_pkg::*;

  // a stalled result holds its payload
  `RFT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))

  // loading and streaming never overlap
  `RFT_ASSERT_IMPL(a_no_overlap, clk_i, rst_ni, 1'b1, !(in_ready_o && out_valid_o))

  // the last byte of a message closes the input side
  `RFT_ASSERT_NEXT(a_last_in_closes, clk_i, rst_ni, in_valid_i && in_ready_o && in_data_i.in_last, !in_ready_o)

  // taking the final result reopens the input side at once
  `RFT_ASSERT_NEXT(a_last_out_opens, clk_i, rst_ni, out_valid_o && out_ready_i && out_data_o.out_last, in_ready_o)

endmodule

bind rail_fence_transposer rft_checker u_checker (.*);

[bench/tb_rail_fence_transposer.sv]
// ----------------------------------------------------------------------------
// Rail fence transposer testbench
// Loads messages over the input channel and predicts the zigzag transposition
// (or its inverse) of each one. Every emitted byte is checked against the
// predicted stream, field by field. Rail count and mode are set over APB
// between messages and once mid-message. The run covers directed corner cases,
// buffer overflow, a long output stall, and random messages under three idle patterns.
// ----------------------------------------------------------------------------
module tb_rail_fence_transposer;
  import rft_pkg::*;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  rft_in_t             in_data_i;
  logic                out_valid_o;
  logic                out_ready_i;
  rft_out_t            out_data_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PaddrW-1:0]   paddr;
  logic [PdataW-1:0]   pwdata;
  logic [PdataW-1:0]   prdata;
  logic                pready;

  rail_fence_transposer uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // shadow of the block's message buffer and registers
  logic [7:0]  msg_buf [MaxLen];
  int unsigned msg_len;
  logic        msg_ovf;
  logic [6:0]  cfg_rails;
  logic        cfg_decrypt;

  rft_out_t    transposed_q [$];
  int          err_cnt;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          stall_req;
  int          stall_ack;
  int          stall_left;

  always #5 clk_i = ~clk_i;

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // receiver: random ready, or a long hold-off when requested
  always @(negedge clk_i) begin
    if (stall_req != stall_ack) begin
      stall_ack  = stall_req;
      stall_left = 400;
    end
    if (stall_left > 0) begin
      stall_left  = stall_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : check_results
    rft_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (transposed_q.size() == 0) begin
        $error("unexpected item: out_byte %0h out_last %0b truncated %0b",
               out_data_o.out_byte, out_data_o.out_last, out_data_o.truncated);
        err_cnt++;
      end else begin
        want = transposed_q.pop_front();
        if (out_data_o.out_byte !== want.out_byte) begin
          $error("out_byte: expected %0h, got %0h", want.out_byte, out_data_o.out_byte);
          err_cnt++;
        end
        if (out_data_o.out_last !== want.out_last) begin
          $error("out_last: expected %0b, got %0b", want.out_last, out_data_o.out_last);
          err_cnt++;
        end
        if (out_data_o.truncated !== want.truncated) begin
          $error("truncated: expected %0b, got %0b", want.truncated,
                 out_data_o.truncated);
          err_cnt++;
        end
      end
    end
  end

  // store one accepted byte; on the last mark queue the transposed message
  task automatic predict_transposition(input rft_in_t item);
    int unsigned order [MaxLen];
    logic [7:0]  outb [MaxLen];
    int unsigned n;
    int unsigned k;
    int unsigned period;
    int unsigned m;
    int unsigned rail;
    rft_out_t    res;
    if (msg_len < MaxLen) begin
      msg_buf[msg_len] = item.in_byte;
      msg_len++;
    end else begin
      msg_ovf = 1'b1;
    end
    if (!item.in_last) return;
    n = msg_len;
    if (cfg_rails <= 1) begin
      for (int i = 0; i < n; i++) order[i] = i;
    end else begin
      period = 2 * (cfg_rails - 1);
      k = 0;
      for (int r = 0; r < cfg_rails; r++) begin
        for (int i = 0; i < n; i++) begin
          m    = i % period;
          rail = (m < cfg_rails) ? m : period - m;
          if (rail == r) begin
            order[k] = i;
            k++;
          end
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      if (cfg_decrypt) outb[order[i]] = msg_buf[i];
      else outb[i] = msg_buf[order[i]];
    end
    for (int i = 0; i < n; i++) begin
      res.out_byte  = outb[i];
      res.out_last  = (i + 1 == n);
      res.truncated = msg_ovf;
      transposed_q.push_back(res);
    end
    msg_len = 0;
    msg_ovf = 1'b0;
  endtask

  task automatic send_byte(input logic [7:0] data, input logic last);
    rft_in_t item;
    item.in_byte = data;
    item.in_last = last;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    predict_transposition(item);
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) send_byte(8'($urandom_range(255)), i == len - 1);
  endtask

  // drop valid and hold until every expected item is out and the block settles
  task automatic wait_idle;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (transposed_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic idx, input logic [PdataW-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PaddrW'({idx, 2'b00});
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == RegIdxRail) cfg_rails = data[6:0];
    else cfg_decrypt = data[0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // upper data bits carry noise; only the register's own bits count
  task automatic set_config(input logic [6:0] rails, input logic decrypt);
    wait_idle();
    apb_write(RegIdxRail, ($urandom() & ~32'h7F) | PdataW'(rails));
    apb_write(RegIdxMode, ($urandom() & ~32'h1) | PdataW'(decrypt));
  endtask

  task automatic random_config;
    logic [6:0] rails;
    case ($urandom_range(5))
      0: rails = 7'd0;
      1: rails = 7'd1;
      2: rails = 7'd2;
      3: rails = 7'($urandom_range(3, 64));
      4: rails = 7'd64;
      default: rails = 7'($urandom_range(65, 127));
    endcase
    set_config(rails, 1'($urandom_range(1)));
  endtask

  task automatic test_directed;
    send_idle_pct = 6;
    recv_idle_pct = 63;
    // reset values: 3 rails, encrypt; byte extremes and a newline byte
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h0A, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b1);
    send_byte(8'h80, 1'b1);
    set_config(7'd0, 1'b0);
    send_message(3);
    set_config(7'd1, 1'b1);
    send_message(2);
    set_config(7'd2, 1'b1);
    send_message(4);
    // rail count at or above message length, then beyond buffer size
    set_config(7'd64, 1'b0);
    send_message(3);
    set_config(7'd127, 1'b1);
    send_message(3);
    // change registers in the middle of a message
    send_byte(8'h3C, 1'b0);
    send_byte(8'hC3, 1'b0);
    set_config(7'd5, 1'b0);
    send_byte(8'h01, 1'b1);
    wait_idle();
  endtask

  task automatic test_overflow;
    set_config(7'($urandom_range(2, 8)), 1'b0);
    send_message(MaxLen);
    set_config(7'($urandom_range(2, 8)), 1'b1);
    send_message(MaxLen + 1);
    wait_idle();
  endtask

  task automatic test_output_stall;
    send_idle_pct = 0;
    recv_idle_pct = 20;
    set_config(7'd4, 1'b0);
    stall_req++;
    send_message(16);
    send_message(16);
    send_message(16);
    wait_idle();
  endtask

  task automatic test_random(input int s_pct, input int r_pct, input int budget);
    int sent;
    int len;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(3) == 0) random_config();
      case ($urandom_range(9))
        7, 8: len = $urandom_range(13, MaxLen);
        9: len = $urandom_range(MaxLen + 1, MaxLen + 8);
        default: len = $urandom_range(1, 12);
      endcase
      send_message(len);
      sent += len;
    end
    wait_idle();
  endtask

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    msg_len       = 0;
    msg_ovf       = 1'b0;
    cfg_rails     = RailReset;
    cfg_decrypt   = 1'b0;
    err_cnt       = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_req     = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_overflow();
    test_output_stall();
    test_random(6, 63, 30);
    test_random(63, 6, 30);
    test_random(0, 0, 30);

    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
